// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL; clk and rst_n must exist at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BARS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BARS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BARS_ASSERT(lbl, prop)
`define BARS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/bars_pkg.sv -----
`default_nettype none
package bars_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int DIM_W      = 11;
  localparam int COL_W      = 10;
  localparam int RAD9_W     = 9;
  localparam int CNT_W      = 16;
  localparam int IDX_W      = 3;
  localparam int DATA_W     = 16;
  localparam int SQ_W       = 2 * RAD9_W;
  localparam int ROOT_W     = RAD9_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W + 1);
  localparam int POS_W      = COL_W + 2;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [DIM_W-1:0]  MAX_SIDE_V  = DIM_W'(MAX_SIDE);
  localparam logic [DIM_W-1:0]  RST_WIDTH   = 11'd240;
  localparam logic [DIM_W-1:0]  RST_HEIGHT  = 11'd240;
  localparam logic [RAD9_W-1:0] RST_OUTER   = 9'd118;
  localparam logic [RAD9_W-1:0] RST_THICK   = 9'd20;
  localparam logic [CNT_W-1:0]  RST_FLASH   = 16'd10000;
  localparam logic [CNT_W-1:0]  RST_BLINK   = 16'd500;
  localparam logic [15:0]       COLOR_MIL   = 16'hD882;
  localparam logic [15:0]       COLOR_TRK   = 16'h0666;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BUF_WIDTH  = 3'd0,
    REG_BUF_HEIGHT = 3'd1,
    REG_OUTER      = 3'd2,
    REG_THICK      = 3'd3,
    REG_FLASH      = 3'd4,
    REG_BLINK      = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_ROOT_O,
    B_ROOT_I,
    B_FIN
  } bstate_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic              active;
    logic              ended;
    logic              draw;
    logic              mil;
    logic              query;
    logic [RAD9_W-1:0] dy;
    logic [RAD9_W-1:0] ro;
    logic [RAD9_W-1:0] ri;
    logic [COL_W-1:0]  cx;
    logic [DIM_W-1:0]  w;
  } item_t;

  typedef struct packed {
    logic             ok;
    logic [COL_W-1:0] s;
    logic [COL_W-1:0] e;
  } span_t;

  function automatic span_t clip_span(input logic signed [POS_W-1:0] a,
                                      input logic signed [POS_W-1:0] b,
                                      input logic [DIM_W-1:0] w);
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] wm1;
    span_t sp;
    wm1 = $signed({1'b0, w}) - POS_W'(1);
    lo = (a < $signed(POS_W'(0))) ? $signed(POS_W'(0)) : a;
    hi = (b > wm1) ? wm1 : b;
    sp.ok = !(lo > hi);
    sp.s = sp.ok ? lo[COL_W-1:0] : '0;
    sp.e = sp.ok ? hi[COL_W-1:0] : '0;
    return sp;
  endfunction

endpackage
`default_nettype wire

// ----- sv/bars_front.sv -----
`default_nettype none
module bars_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_op,
  input  logic                                 in_military,
  input  logic [bars_pkg::COL_W-1:0]           in_row,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bars_pkg::IDX_W-1:0]           cfg_index,
  input  logic [bars_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                 q_full,
  output logic                                 q_push,
  output bars_pkg::item_t                      q_item
);
  import bars_pkg::*;

  logic [DIM_W-1:0]  buf_w_r, buf_h_r;
  logic [RAD9_W-1:0] outer_r, thick_r;
  logic [CNT_W-1:0]  flash_r, blink_r;

  logic              alert_on_r, alert_on_nxt;
  logic              kind_mil_r, kind_mil_nxt;
  logic [CNT_W-1:0]  elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]  blink_cnt_r, blink_cnt_nxt;
  logic              blink_odd_r, blink_odd_nxt;
  logic              ended;

  op_t               op;
  logic [DIM_W-1:0]  w, h;
  logic [COL_W-1:0]  cy;
  logic signed [POS_W-1:0] dy;
  logic [POS_W-1:0]  ady;
  logic [RAD9_W-1:0] ri;
  logic              hit;

  assign op        = op_t'(in_op);
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_w_r <= RST_WIDTH;
      buf_h_r <= RST_HEIGHT;
      outer_r <= RST_OUTER;
      thick_r <= RST_THICK;
      flash_r <= RST_FLASH;
      blink_r <= RST_BLINK;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BUF_WIDTH:  buf_w_r <= cfg_data[DIM_W-1:0];
        REG_BUF_HEIGHT: buf_h_r <= cfg_data[DIM_W-1:0];
        REG_OUTER:      outer_r <= cfg_data[RAD9_W-1:0];
        REG_THICK:      thick_r <= cfg_data[RAD9_W-1:0];
        REG_FLASH:      flash_r <= cfg_data[CNT_W-1:0];
        REG_BLINK:      blink_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // alert timer
  always_comb begin
    alert_on_nxt  = alert_on_r;
    kind_mil_nxt  = kind_mil_r;
    elapsed_nxt   = elapsed_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_odd_nxt = blink_odd_r;
    ended         = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (alert_on_r) begin
          elapsed_nxt   = (elapsed_r == '1) ? elapsed_r : elapsed_r + CNT_W'(1);
          blink_cnt_nxt = blink_cnt_r + CNT_W'(1);
          if (blink_cnt_nxt >= blink_r) begin
            blink_cnt_nxt = '0;
            blink_odd_nxt = ~blink_odd_r;
          end
          if (elapsed_nxt >= flash_r) begin
            alert_on_nxt  = 1'b0;
            elapsed_nxt   = '0;
            blink_cnt_nxt = '0;
            blink_odd_nxt = 1'b0;
            ended         = 1'b1;
          end
        end
      end
      OP_START: begin
        // military is never downgraded while the alert runs
        if (!alert_on_r || in_military) kind_mil_nxt = in_military;
        alert_on_nxt  = 1'b1;
        elapsed_nxt   = '0;
        blink_cnt_nxt = '0;
        blink_odd_nxt = 1'b0;
      end
      OP_QUERY: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alert_on_r  <= 1'b0;
      kind_mil_r  <= 1'b0;
      elapsed_r   <= '0;
      blink_cnt_r <= '0;
      blink_odd_r <= 1'b0;
    end else if (q_push) begin
      alert_on_r  <= alert_on_nxt;
      kind_mil_r  <= kind_mil_nxt;
      elapsed_r   <= elapsed_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      blink_odd_r <= blink_odd_nxt;
    end
  end

  // row geometry
  assign w   = (buf_w_r > MAX_SIDE_V) ? MAX_SIDE_V : buf_w_r;
  assign h   = (buf_h_r > MAX_SIDE_V) ? MAX_SIDE_V : buf_h_r;
  assign cy  = h[DIM_W-1:1];
  assign dy  = $signed({2'b00, in_row}) - $signed({2'b00, cy});
  assign ady = dy[POS_W-1] ? POS_W'(-dy) : POS_W'(dy);
  assign ri  = (outer_r >= thick_r) ? outer_r - thick_r : '0;
  assign hit = (op == OP_QUERY) && (w != '0) && (h != '0) && ({1'b0, in_row} < h)
            && (ady <= {{(POS_W-RAD9_W){1'b0}}, outer_r});

  always_comb begin
    q_item.active = alert_on_nxt;
    q_item.ended  = ended;
    q_item.draw   = alert_on_nxt && !blink_odd_nxt;
    q_item.mil    = kind_mil_nxt;
    q_item.query  = hit;
    q_item.dy     = ady[RAD9_W-1:0];
    q_item.ro     = outer_r;
    q_item.ri     = ri;
    q_item.cx     = w[DIM_W-1:1];
    q_item.w      = w;
  end

endmodule
`default_nettype wire

// ----- sv/bars_fifo.sv -----
`default_nettype none
`include "assert_macros.svh"
module bars_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bars_pkg::item_t item_in,
  input  logic            pop,
  output bars_pkg::item_t item_out,
  output logic            full,
  output logic            empty
);
  import bars_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0]  count_r;

  assign full     = (count_r == FCNT_W'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign item_out = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= item_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)
        count_r <= count_r + FCNT_W'(1);
      else if (pop && !push)
        count_r <= count_r - FCNT_W'(1);
    end
  end

  `BARS_ASSERT(a_no_overflow, push |-> !full)
  `BARS_ASSERT(a_no_underflow, pop |-> !empty)

endmodule
`default_nettype wire

// ----- sv/bars_isqrt.sv -----
`default_nettype none
`include "assert_macros.svh"
module bars_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bars_pkg::SQ_W-1:0]   rad,
  output logic                        busy,
  output logic                        done,
  output logic [bars_pkg::ROOT_W-1:0] root
);
  import bars_pkg::*;

  logic [SQ_W-1:0]   rad_r, val_r;
  logic [REM_W-1:0]  rem_r, cur, trial;
  logic [ROOT_W-1:0] root_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic              ge;

  // two radicand bits per step, restoring remainder
  assign cur   = {rem_r[ROOT_W:0], val_r[SQ_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (cur >= trial);

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      val_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[SQ_W-3:0], 2'b00};
      rem_r  <= ge ? cur - trial : cur;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(ROOT_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  `BARS_ASSERT(a_root_exact, done_r |->
    (({{ROOT_W{1'b0}}, root_r} * {{ROOT_W{1'b0}}, root_r}) <= {rad_r, 2'b00} >> 2) &&
    ((({{ROOT_W{1'b0}}, root_r} + (2*ROOT_W)'(1)) *
      ({{ROOT_W{1'b0}}, root_r} + (2*ROOT_W)'(1))) > {2'b00, rad_r}))

endmodule
`default_nettype wire

// ----- sv/bars_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module bars_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  bars_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_active,
  output logic                         out_ended,
  output logic                         out_draw_ring,
  output logic [15:0]                  out_ring_rgb,
  output logic [1:0]                   out_span_count,
  output logic [bars_pkg::COL_W-1:0]   out_span0_start,
  output logic [bars_pkg::COL_W-1:0]   out_span0_end,
  output logic [bars_pkg::COL_W-1:0]   out_span1_start,
  output logic [bars_pkg::COL_W-1:0]   out_span1_end
);
  import bars_pkg::*;

  bstate_t           state_r, state_nxt;
  item_t             rec_r;
  logic [1:0]        sq_idx_r;
  logic [SQ_W-1:0]   dy2_r, ro2_r, ri2_r;
  logic [ROOT_W-1:0] xo_r, xi_r;
  logic              two_r;

  logic [RAD9_W-1:0] mul_a;
  logic [SQ_W-1:0]   prod;
  logic              rt_start, rt_busy, rt_done;
  logic [SQ_W-1:0]   rt_rad;
  logic [ROOT_W-1:0] rt_root;
  logic              out_load;

  logic signed [POS_W-1:0] cxs, xos, xis;
  span_t             spa, spb, s0, s1;
  logic [1:0]        cnt;

  logic              out_valid_r;
  logic              active_r, ended_r, draw_r;
  logic [15:0]       color_r;
  logic [1:0]        count_r;
  span_t             s0_r, s1_r;

  bars_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .rad   (rt_rad),
    .busy  (rt_busy),
    .done  (rt_done),
    .root  (rt_root)
  );

  // one shared squarer: dy, outer radius, inner radius
  always_comb begin
    case (sq_idx_r)
      2'd0:    mul_a = rec_r.dy;
      2'd1:    mul_a = rec_r.ro;
      default: mul_a = rec_r.ri;
    endcase
  end
  assign prod = mul_a * mul_a;

  assign out_load = (state_r == B_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    rt_start  = 1'b0;
    rt_rad    = ro2_r - dy2_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = q_item.query ? B_SQ : B_FIN;
        end
      end
      B_SQ: begin
        if (sq_idx_r == 2'd2) begin
          rt_start  = 1'b1;
          state_nxt = B_ROOT_O;
        end
      end
      B_ROOT_O: begin
        if (rt_done) begin
          rt_rad = ri2_r - dy2_r;
          if (dy2_r >= ri2_r) begin
            state_nxt = B_FIN;
          end else begin
            rt_start  = 1'b1;
            state_nxt = B_ROOT_I;
          end
        end
      end
      B_ROOT_I: begin
        if (rt_done) state_nxt = B_FIN;
      end
      B_FIN: begin
        if (out_load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r    <= q_item;
      sq_idx_r <= '0;
    end
    if (state_r == B_SQ) begin
      sq_idx_r <= sq_idx_r + 2'd1;
      case (sq_idx_r)
        2'd0:    dy2_r <= prod;
        2'd1:    ro2_r <= prod;
        default: ri2_r <= prod;
      endcase
    end
    if (state_r == B_ROOT_O && rt_done) begin
      xo_r  <= rt_root;
      two_r <= (dy2_r < ri2_r);
    end
    if (state_r == B_ROOT_I && rt_done) xi_r <= rt_root;
  end

  // span ends and clipping
  assign cxs = $signed({2'b00, rec_r.cx});
  assign xos = $signed({{(POS_W-ROOT_W){1'b0}}, xo_r});
  assign xis = $signed({{(POS_W-ROOT_W){1'b0}}, xi_r});

  always_comb begin
    spa = '0;
    spb = '0;
    if (rec_r.query) begin
      if (two_r) begin
        spa = clip_span(cxs - xos, cxs - xis - POS_W'(1), rec_r.w);
        spb = clip_span(cxs + xis + POS_W'(1), cxs + xos, rec_r.w);
      end else begin
        spa = clip_span(cxs - xos, cxs + xos, rec_r.w);
      end
    end
    cnt = {1'b0, spa.ok} + {1'b0, spb.ok};
    if (spa.ok) begin
      s0 = spa;
      s1 = spb;
    end else begin
      s0 = spb;
      s1 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      active_r <= rec_r.active;
      ended_r  <= rec_r.ended;
      draw_r   <= rec_r.draw;
      color_r  <= rec_r.mil ? COLOR_MIL : COLOR_TRK;
      count_r  <= cnt;
      s0_r     <= s0;
      s1_r     <= s1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_active      = active_r;
  assign out_ended       = ended_r;
  assign out_draw_ring   = draw_r;
  assign out_ring_rgb    = color_r;
  assign out_span_count  = count_r;
  assign out_span0_start = s0_r.s;
  assign out_span0_end   = s0_r.e;
  assign out_span1_start = s1_r.s;
  assign out_span1_end   = s1_r.e;

  `BARS_ASSERT(a_ended_inactive, out_valid_r && ended_r |-> !active_r && !draw_r)
  `BARS_ASSERT(a_empty_spans, out_valid_r && count_r == 2'd0 |->
    s0_r.s == '0 && s0_r.e == '0 && s1_r.s == '0 && s1_r.e == '0)
  `BARS_ASSERT_NEXT(a_root_busy, rt_start, rt_busy && !rt_done)

endmodule
`default_nettype wire

// ----- sv/blinking_alert_ring_spans.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_op, in_military, in_row
// out       out_valid / out_ready  out_active .. out_span1_end
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Ticks, starts and undefined ops go from the pop straight to the output load in the back
// end; a row query pops, squares dy and the outer and inner radii, runs the 9-step square
// root unit once, or twice when the row cuts the inner disc, and then loads the output.
// The front end classifies a request in its accept cycle and queues it (2 deep),
// so in_ready drops only when the queue is full. Reset is synchronous, active low,
// and loads the default geometry and timing. cfg_ready is always high.
`default_nettype none
module blinking_alert_ring_spans (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic                               in_military,
  input  logic [bars_pkg::COL_W-1:0]         in_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_active,
  output logic                               out_ended,
  output logic                               out_draw_ring,
  output logic [15:0]                        out_ring_rgb,
  output logic [1:0]                         out_span_count,
  output logic [bars_pkg::COL_W-1:0]         out_span0_start,
  output logic [bars_pkg::COL_W-1:0]         out_span0_end,
  output logic [bars_pkg::COL_W-1:0]         out_span1_start,
  output logic [bars_pkg::COL_W-1:0]         out_span1_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bars_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bars_pkg::DATA_W-1:0]        cfg_data
);
  import bars_pkg::*;

  item_t q_in, q_out;
  logic  q_push, q_pop, q_full, q_empty;

  bars_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_military (in_military),
    .in_row      (in_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  bars_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (q_in),
    .pop      (q_pop),
    .item_out (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  bars_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_active      (out_active),
    .out_ended       (out_ended),
    .out_draw_ring   (out_draw_ring),
    .out_ring_rgb    (out_ring_rgb),
    .out_span_count  (out_span_count),
    .out_span0_start (out_span0_start),
    .out_span0_end   (out_span0_end),
    .out_span1_start (out_span1_start),
    .out_span1_end   (out_span1_end)
  );

endmodule
`default_nettype wire
